// ===== hdl/kbde_pkg.sv =====
// ----------------------------------------------------------------------------
// kbde_pkg
// Shared types and constants of the keyboard report to key event converter.
// ----------------------------------------------------------------------------
`default_nettype none

package kbde_pkg;

   localparam int NUM_KEYS = 6;
   localparam int NUM_MODS = 8;

   // pending event vector: modifiers, releases, presses, disconnect
   localparam int GONE_LO  = NUM_MODS;
   localparam int FRESH_LO = NUM_MODS + NUM_KEYS;
   localparam int DISC_BIT = NUM_MODS + 2 * NUM_KEYS;
   localparam int PEND_W   = DISC_BIT + 1;

   localparam logic [7:0] MOD_BASE = 8'hE0;
   localparam logic [7:0] ERR_LO   = 8'h01;
   localparam logic [7:0] ERR_HI   = 8'h03;
   localparam logic [7:0] MIN_LEN  = 8'd8;

   localparam logic OP_REPORT  = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic EV_KEY  = 1'b0;
   localparam logic EV_DISC = 1'b1;

   typedef logic [7:0] usage_type;
   typedef usage_type [NUM_KEYS-1:0] keys_type;

   typedef struct packed {
      logic gone;
      logic fresh;
   } key_flags_type;

endpackage

`default_nettype wire

// ===== hdl/keyboard_report_diff_events.sv =====
// ----------------------------------------------------------------------------
// keyboard_report_diff_events
// Boot keyboard reports in, key press/release and disconnect events out.
// ----------------------------------------------------------------------------
// One item is worked on at a time. After acceptance, the lookup, table read
// and diff states (plus a free state on a release all) precede the events,
// which leave one per cycle, while the result side does not stall, through a
// single output register; the item ends in the cycle after its last event is
// loaded. An item can be dropped at lookup or, for an error report, at the
// table read. Lookup compares all MAX_CONNS entries in parallel lanes and six
// key lanes find released and pressed keys at once.
`default_nettype none

module keyboard_report_diff_events #(
   parameter int MAX_CONNS = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // conn_id, report_length, modifier_bits, key_slot_a .. key_slot_f
   input  wire logic [79:0] req_tdata,
   // opcode
   input  wire logic [0:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // event_conn, usage_code, is_pressed, zero fill
   output logic [31:0]      rsp_tdata,
   // event_kind
   output logic [0:0]       rsp_tuser,
   output logic             rsp_tlast
);

   localparam int IW = (MAX_CONNS > 1) ? $clog2(MAX_CONNS) : 1;
   localparam int CW = $clog2(MAX_CONNS + 1);
   localparam int NK = kbde_pkg::NUM_KEYS;
   localparam int PW = kbde_pkg::PEND_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOOKUP, ST_READ, ST_DIFF, ST_FREE, ST_EMIT
   } state_type;

   state_type state_ff;

   // entry table
   logic [15:0]        entry_conn_ff [MAX_CONNS];
   logic [7:0]         entry_mods_ff [MAX_CONNS];
   kbde_pkg::keys_type entry_keys_ff [MAX_CONNS];
   logic [CW-1:0]      used_ff;

   // item registers
   logic               op_ff;
   logic [15:0]        conn_ff;
   logic [7:0]         len_ff;
   logic [7:0]         new_mods_ff;
   kbde_pkg::keys_type new_keys_ff;

   logic [IW-1:0]      idx_ff;
   logic [15:0]        rd_conn_ff;
   logic [7:0]         rd_mods_ff;
   kbde_pkg::keys_type rd_keys_ff;
   kbde_pkg::keys_type old_keys_ff;
   logic [PW-1:0]      pend_ff;

   logic               rsp_tvalid_ff;
   logic [31:0]        rsp_tdata_ff;
   logic               rsp_kind_ff;
   logic               rsp_last_ff;

   // ---------------- lookup lanes and merge ----------------
   logic [MAX_CONNS-1:0] hit;
   logic                 hit_any;
   logic [IW-1:0]        hit_idx;

   for (genvar g = 0; g < MAX_CONNS; g++) begin : g_conn
      kbde_conn_lane u_lane (
         .entry_conn (entry_conn_ff[g]),
         .entry_live (CW'(g) < used_ff),
         .conn       (conn_ff),
         .hit        (hit[g])
      );
   end

   always_comb begin
      hit_idx = '0;
      for (int i = MAX_CONNS - 1; i >= 0; i--) begin
         if (hit[i]) hit_idx = IW'(i);
      end
   end

   assign hit_any = |hit;

   // ---------------- key lanes ----------------
   kbde_pkg::key_flags_type flags [NK];
   logic [NK-1:0]           gone;
   logic [NK-1:0]           fresh;

   for (genvar k = 0; k < NK; k++) begin : g_key
      kbde_key_lane u_lane (
         .own_old  (rd_keys_ff[k]),
         .own_new  (new_keys_ff[k]),
         .old_keys (rd_keys_ff),
         .new_keys (new_keys_ff),
         .flags    (flags[k])
      );
      assign gone[k]  = flags[k].gone;
      assign fresh[k] = flags[k].fresh;
   end

   // ---------------- misc decode ----------------
   logic          err_any;
   logic [CW-1:0] last_cnt;
   logic [IW-1:0] rd_addr;

   always_comb begin
      err_any = 1'b0;
      for (int k = 0; k < NK; k++) begin
         if (new_keys_ff[k] >= kbde_pkg::ERR_LO && new_keys_ff[k] <= kbde_pkg::ERR_HI)
            err_any = 1'b1;
      end
   end

   assign last_cnt = used_ff - CW'(1);
   // read the last entry during the diff so a release can move it down
   assign rd_addr  = (state_ff == ST_DIFF) ? last_cnt[IW-1:0] : idx_ff;

   always_ff @(posedge clock) begin
      rd_conn_ff <= entry_conn_ff[rd_addr];
      rd_mods_ff <= entry_mods_ff[rd_addr];
      rd_keys_ff <= entry_keys_ff[rd_addr];
   end

   // ---------------- event pick ----------------
   logic [PW-1:0] pick;
   logic [7:0]    ev_usage;
   logic          ev_press;
   logic          ev_kind;
   logic          ev_last;

   always_comb begin
      pick     = pend_ff & (~pend_ff + PW'(1));
      ev_usage = '0;
      ev_press = 1'b0;
      ev_kind  = kbde_pkg::EV_KEY;
      for (int b = 0; b < kbde_pkg::NUM_MODS; b++) begin
         if (pick[b]) begin
            ev_usage = kbde_pkg::MOD_BASE | 8'(b);
            ev_press = new_mods_ff[b];
         end
      end
      for (int k = 0; k < NK; k++) begin
         if (pick[kbde_pkg::GONE_LO + k]) begin
            ev_usage = old_keys_ff[k];
            ev_press = 1'b0;
         end
         if (pick[kbde_pkg::FRESH_LO + k]) begin
            ev_usage = new_keys_ff[k];
            ev_press = 1'b1;
         end
      end
      if (pick[kbde_pkg::DISC_BIT]) ev_kind = kbde_pkg::EV_DISC;
      ev_last = (pend_ff & ~pick) == '0;
   end

   logic load;
   assign load = (state_ff == ST_EMIT) && (pend_ff != '0) && (!rsp_tvalid_ff || rsp_tready);

   // ---------------- control ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         pend_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (load) begin
            rsp_tvalid_ff <= 1'b1;
            rsp_tdata_ff  <= {7'b0, ev_press, ev_usage, conn_ff};
            rsp_kind_ff   <= ev_kind;
            rsp_last_ff   <= ev_last;
            pend_ff       <= pend_ff & ~pick;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  op_ff   <= req_tuser[0];
                  conn_ff <= req_tdata[15:0];
                  len_ff  <= req_tdata[23:16];
                  if (req_tuser[0] == kbde_pkg::OP_RELEASE) begin
                     new_mods_ff <= '0;
                     new_keys_ff <= '0;
                  end else begin
                     new_mods_ff <= req_tdata[31:24];
                     new_keys_ff <= req_tdata[79:32];
                  end
                  state_ff <= ST_LOOKUP;
               end
            end
            ST_LOOKUP: begin
               if (op_ff == kbde_pkg::OP_REPORT) begin
                  if (len_ff < kbde_pkg::MIN_LEN) begin
                     state_ff <= ST_IDLE;
                  end else if (hit_any) begin
                     idx_ff   <= hit_idx;
                     state_ff <= ST_READ;
                  end else if (used_ff == CW'(MAX_CONNS)) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     // allocate a cleared entry at the end of the table
                     idx_ff                            <= used_ff[IW-1:0];
                     entry_conn_ff[used_ff[IW-1:0]]    <= conn_ff;
                     entry_mods_ff[used_ff[IW-1:0]]    <= '0;
                     entry_keys_ff[used_ff[IW-1:0]]    <= '0;
                     used_ff                           <= used_ff + CW'(1);
                     state_ff                          <= ST_READ;
                  end
               end else begin
                  if (hit_any) begin
                     idx_ff   <= hit_idx;
                     state_ff <= ST_READ;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_READ: begin
               // drop error reports; an allocated entry stays
               if (op_ff == kbde_pkg::OP_REPORT && err_any) state_ff <= ST_IDLE;
               else                                         state_ff <= ST_DIFF;
            end
            ST_DIFF: begin
               pend_ff     <= {op_ff == kbde_pkg::OP_RELEASE, fresh, gone,
                               rd_mods_ff ^ new_mods_ff};
               old_keys_ff <= rd_keys_ff;
               if (op_ff == kbde_pkg::OP_REPORT) begin
                  entry_mods_ff[idx_ff] <= new_mods_ff;
                  entry_keys_ff[idx_ff] <= new_keys_ff;
                  state_ff              <= ST_EMIT;
               end else begin
                  state_ff <= ST_FREE;
               end
            end
            ST_FREE: begin
               // move the last entry into the freed place
               entry_conn_ff[idx_ff] <= rd_conn_ff;
               entry_mods_ff[idx_ff] <= rd_mods_ff;
               entry_keys_ff[idx_ff] <= rd_keys_ff;
               used_ff               <= last_cnt;
               state_ff              <= ST_EMIT;
            end
            ST_EMIT: begin
               if (pend_ff == '0) state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== hdl/kbde_conn_lane.sv =====
// ----------------------------------------------------------------------------
// kbde_conn_lane
// One table entry's lookup lane: flags a live entry that holds the connection.
// ----------------------------------------------------------------------------
`default_nettype none

module kbde_conn_lane (
   input  wire logic [15:0] entry_conn,
   input  wire logic        entry_live,
   input  wire logic [15:0] conn,
   output logic             hit
);

   assign hit = entry_live && (entry_conn == conn);

endmodule

`default_nettype wire

// ===== hdl/kbde_key_lane.sv =====
// ----------------------------------------------------------------------------
// kbde_key_lane
// One key slot's lane: finds whether its old key is gone and its new key fresh.
// ----------------------------------------------------------------------------
`default_nettype none

module kbde_key_lane (
   input  wire kbde_pkg::usage_type     own_old,
   input  wire kbde_pkg::usage_type     own_new,
   input  wire kbde_pkg::keys_type      old_keys,
   input  wire kbde_pkg::keys_type      new_keys,
   output kbde_pkg::key_flags_type      flags
);

   logic old_held;
   logic new_held;

   always_comb begin
      old_held = 1'b0;
      new_held = 1'b0;
      for (int j = 0; j < kbde_pkg::NUM_KEYS; j++) begin
         if (new_keys[j] == own_old) old_held = 1'b1;
         if (old_keys[j] == own_new) new_held = 1'b1;
      end
      flags.gone  = (own_old != '0) && !old_held;
      flags.fresh = (own_new != '0) && !new_held;
   end

endmodule

`default_nettype wire
